// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// label: antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/srfc_pkg.sv -----
// ---------------------------------------------------------------------------
// srfc_pkg
// Types and constants of the serial remote frame controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srfc_pkg;

    localparam int SENT_BYTES  = 2;
    localparam int FRAME_BYTES = 8;
    localparam int REPLY_DEPTH = 6;

    localparam int BP_W  = 10;
    localparam int GAP_W = 16;
    localparam int CMD_W = 8;
    localparam int ET_W  = 16;
    localparam int BI_W  = 7;
    localparam int THR_W = 14;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [BP_W-1:0]  BIT_PERIOD_RST = 10'd104;
    localparam logic [GAP_W-1:0] SYNC_GAP_RST   = 16'd3000;

    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_SYNC_GAP   = 2'd1;
    localparam logic [1:0] REG_CMD_FIRST  = 2'd2;
    localparam logic [1:0] REG_CMD_SECOND = 2'd3;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_SYNC       = 3'd0;
    localparam t_phase PH_WAIT_FIRST = 3'd1;
    localparam t_phase PH_TX_BIT     = 3'd2;
    localparam t_phase PH_TX_STOP    = 3'd3;
    localparam t_phase PH_WAIT_NEXT  = 3'd4;
    localparam t_phase PH_RX_BIT     = 3'd5;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  drive_strobe;
        logic  drive_value;
        logic  release_strobe;
        logic  frame_done;
        t_byte reply2;
        t_byte reply3;
        t_byte reply4;
        t_byte reply5;
        t_byte reply6;
        t_byte reply7;
    } t_result;

endpackage

// ----- sv/serial_remote_frame_controller.sv -----
// Result: valid in the cycle after its line sample is accepted.
// Throughput: one sample per cycle while the result side does not stall; the
// state update and all threshold compares fit between the sample handshake and the result register.
// Reset (synchronous, active low): registers to defaults, phase to sync
// search, counters and reply store to zero, result register empty.
// ---------------------------------------------------------------------------
// serial_remote_frame_controller
// Bus master that frames two command bytes out and six reply bytes in, timed
// from each start edge in microsecond ticks, with an APB register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_remote_frame_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_line_level,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_drive_strobe,
    output logic                       o_drive_value,
    output logic                       o_release_strobe,
    output logic                       o_frame_done,
    output logic [7:0]                 o_reply_byte2,
    output logic [7:0]                 o_reply_byte3,
    output logic [7:0]                 o_reply_byte4,
    output logic [7:0]                 o_reply_byte5,
    output logic [7:0]                 o_reply_byte6,
    output logic [7:0]                 o_reply_byte7,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srfc_pkg::ADDR_W-1:0] paddr,
    input  logic [srfc_pkg::DATA_W-1:0] pwdata,
    output logic [srfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import srfc_pkg::*;

    logic [BP_W-1:0]  r_bit_period;
    logic [GAP_W-1:0] r_sync_gap;
    logic [CMD_W-1:0] r_cmd_first;
    logic [CMD_W-1:0] r_cmd_second;

    t_phase           r_phase, n_phase;
    logic [ET_W-1:0]  r_elapsed, n_elapsed, inc_elapsed;
    logic [BI_W-1:0]  r_bit_index, n_bit_index;
    t_byte            r_reply [REPLY_DEPTH];
    t_byte            n_reply [REPLY_DEPTH];

    logic             r_out_valid;
    t_result          r_out, n_out;

    logic             in_acc;
    logic             cfg_wr;
    logic [2:0]       bit_no;
    logic [3:0]       byte_no;
    logic [3:0]       bit_no1;
    logic [3:0]       slot;
    logic [THR_W-1:0] half_bp, tx_thr, rx_thr, stop_thr, next_thr;
    logic             cmd_bit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_sync_gap   <= SYNC_GAP_RST;
            r_cmd_first  <= '0;
            r_cmd_second <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BIT_PERIOD: r_bit_period <= pwdata[BP_W-1:0];
                REG_SYNC_GAP:   r_sync_gap   <= pwdata[GAP_W-1:0];
                REG_CMD_FIRST:  r_cmd_first  <= pwdata[CMD_W-1:0];
                REG_CMD_SECOND: r_cmd_second <= pwdata[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BIT_PERIOD: prdata = DATA_W'(r_bit_period);
            REG_SYNC_GAP:   prdata = DATA_W'(r_sync_gap);
            REG_CMD_FIRST:  prdata = DATA_W'(r_cmd_first);
            REG_CMD_SECOND: prdata = DATA_W'(r_cmd_second);
            default:        prdata = '0;
        endcase
    end

    assign bit_no   = r_bit_index[2:0];
    assign byte_no  = r_bit_index[BI_W-1:3];
    assign bit_no1  = {1'b0, bit_no} + 4'd1;
    assign slot     = byte_no - 4'(SENT_BYTES);
    assign half_bp  = THR_W'(r_bit_period >> 1);
    assign tx_thr   = THR_W'(bit_no1) * THR_W'(r_bit_period);
    assign rx_thr   = tx_thr + half_bp;
    assign stop_thr = THR_W'(9) * THR_W'(r_bit_period);
    assign next_thr = THR_W'(10) * THR_W'(r_bit_period) - half_bp;

    assign inc_elapsed = (r_elapsed != '1) ? r_elapsed + ET_W'(1) : r_elapsed;

    always_comb begin
        case (byte_no)
            4'd0:    cmd_bit = r_cmd_first[bit_no];
            4'd1:    cmd_bit = r_cmd_second[bit_no];
            default: cmd_bit = 1'b0;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = inc_elapsed;
        n_bit_index = r_bit_index;
        for (int k = 0; k < REPLY_DEPTH; k++) begin
            n_reply[k] = r_reply[k];
        end
        n_out = '0;

        case (r_phase)
            PH_SYNC: begin
                if (!i_line_level) begin
                    n_elapsed = '0;
                end
                if (n_elapsed > r_sync_gap) begin
                    n_phase = PH_WAIT_FIRST;
                end
            end
            PH_WAIT_FIRST: begin
                if (!i_line_level) begin
                    n_bit_index = '0;
                    n_elapsed   = '0;
                    for (int k = 0; k < REPLY_DEPTH; k++) begin
                        n_reply[k] = '0;
                    end
                    n_phase = PH_TX_BIT;
                end
            end
            PH_TX_BIT: begin
                if (inc_elapsed >= ET_W'(tx_thr)) begin
                    n_out.drive_strobe = 1'b1;
                    n_out.drive_value  = cmd_bit;
                    n_bit_index        = r_bit_index + BI_W'(1);
                    if (bit_no == 3'd7) begin
                        n_phase = PH_TX_STOP;
                    end
                end
            end
            PH_TX_STOP: begin
                if (inc_elapsed >= ET_W'(stop_thr)) begin
                    n_out.release_strobe = 1'b1;
                    n_phase              = PH_WAIT_NEXT;
                end
            end
            PH_WAIT_NEXT: begin
                if (inc_elapsed > ET_W'(next_thr) && !i_line_level) begin
                    n_elapsed = '0;
                    n_phase   = (r_bit_index >= BI_W'(SENT_BYTES * 8)) ? PH_RX_BIT
                                                                      : PH_TX_BIT;
                end
            end
            PH_RX_BIT: begin
                if (inc_elapsed >= ET_W'(rx_thr)) begin
                    if (i_line_level && byte_no >= 4'(SENT_BYTES)
                        && slot < 4'(REPLY_DEPTH)) begin
                        n_reply[slot[2:0]][bit_no] = 1'b1;
                    end
                    n_bit_index = r_bit_index + BI_W'(1);
                    if (bit_no == 3'd7) begin
                        if (n_bit_index >= BI_W'(FRAME_BYTES * 8)) begin
                            n_out.frame_done = 1'b1;
                            n_phase          = PH_SYNC;
                        end else begin
                            n_phase = PH_WAIT_NEXT;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_SYNC;
            end
        endcase

        if (n_out.frame_done) begin
            n_out.reply2 = n_reply[0];
            n_out.reply3 = n_reply[1];
            n_out.reply4 = n_reply[2];
            n_out.reply5 = n_reply[3];
            n_out.reply6 = n_reply[4];
            n_out.reply7 = n_reply[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC;
            r_elapsed   <= '0;
            r_bit_index <= '0;
            for (int k = 0; k < REPLY_DEPTH; k++) begin
                r_reply[k] <= '0;
            end
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_bit_index <= n_bit_index;
            for (int k = 0; k < REPLY_DEPTH; k++) begin
                r_reply[k] <= n_reply[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_drive_strobe   = r_out.drive_strobe;
    assign o_drive_value    = r_out.drive_value;
    assign o_release_strobe = r_out.release_strobe;
    assign o_frame_done     = r_out.frame_done;
    assign o_reply_byte2    = r_out.reply2;
    assign o_reply_byte3    = r_out.reply3;
    assign o_reply_byte4    = r_out.reply4;
    assign o_reply_byte5    = r_out.reply5;
    assign o_reply_byte6    = r_out.reply6;
    assign o_reply_byte7    = r_out.reply7;

    `ASSERT_IMPL(a_done_exclusive, o_valid && o_frame_done, !o_drive_strobe && !o_release_strobe, "frame done with drive or release")
    `ASSERT_IMPL(a_reply_quiet, o_valid && !o_frame_done, o_reply_byte2 == '0 && o_reply_byte7 == '0, "reply bytes outside frame done")
    `ASSERT_NEXT(a_result_follows, in_acc, o_valid, "accepted sample gave no result")
    `ASSERT_IMPL(a_done_to_sync, o_valid && o_frame_done && $past(in_acc), r_phase == PH_SYNC, "frame done without return to sync search")

endmodule

// ----- sim/serial_remote_frame_controller_checker.sv -----
// ----------------------------------------------------------------------------
// Frame controller checker
// Watches the sample and result channels and the register port, keeps its
// own timing and framing state per accepted line sample, and compares every
// result transfer field by field against the oldest predicted tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_remote_frame_controller_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          i_line_level,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_drive_strobe,
    input  logic                          o_drive_value,
    input  logic                          o_release_strobe,
    input  logic                          o_frame_done,
    input  logic [7:0]                    o_reply_byte2,
    input  logic [7:0]                    o_reply_byte3,
    input  logic [7:0]                    o_reply_byte4,
    input  logic [7:0]                    o_reply_byte5,
    input  logic [7:0]                    o_reply_byte6,
    input  logic [7:0]                    o_reply_byte7,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [srfc_pkg::DATA_W-1:0]   pwdata,
    input  logic [srfc_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import srfc_pkg::*;

    logic [BP_W-1:0]  bit_period;
    logic [GAP_W-1:0] sync_gap;
    t_byte            cmd_first;
    t_byte            cmd_second;

    t_phase           line_phase;
    logic [ET_W-1:0]  tick_count;
    logic [BI_W-1:0]  bit_pos;
    t_byte            reply_bytes [REPLY_DEPTH];

    t_result          tick_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // One line sample through the framing state; returns that tick's outputs.
    function automatic t_result frame_tick(input logic lvl);
        int unsigned bit_no;
        int unsigned byte_no;
        int unsigned bp;
        t_result     r;
        r       = '0;
        bit_no  = 32'(bit_pos[2:0]);
        byte_no = 32'(bit_pos[BI_W-1:3]);
        bp      = 32'(bit_period);
        if (tick_count != '1)
            tick_count++;
        case (line_phase)
            PH_SYNC: begin
                if (!lvl)
                    tick_count = '0;
                if (tick_count > sync_gap)
                    line_phase = PH_WAIT_FIRST;
            end
            PH_WAIT_FIRST: begin
                if (!lvl) begin
                    bit_pos     = '0;
                    tick_count  = '0;
                    reply_bytes = '{default: '0};
                    line_phase  = PH_TX_BIT;
                end
            end
            PH_TX_BIT: begin
                if (tick_count >= (bit_no + 1) * bp) begin
                    r.drive_strobe = 1'b1;
                    if (byte_no == 0)
                        r.drive_value = cmd_first[bit_no];
                    else if (byte_no == 1)
                        r.drive_value = cmd_second[bit_no];
                    bit_pos++;
                    if (bit_no == 7)
                        line_phase = PH_TX_STOP;
                end
            end
            PH_TX_STOP: begin
                if (tick_count >= 9 * bp) begin
                    r.release_strobe = 1'b1;
                    line_phase       = PH_WAIT_NEXT;
                end
            end
            PH_WAIT_NEXT: begin
                if (tick_count > 10 * bp - bp / 2 && !lvl) begin
                    tick_count = '0;
                    line_phase = (bit_pos >= SENT_BYTES * 8) ? PH_RX_BIT : PH_TX_BIT;
                end
            end
            PH_RX_BIT: begin
                if (tick_count >= (bit_no + 1) * bp + bp / 2) begin
                    if (lvl && byte_no >= SENT_BYTES && byte_no - SENT_BYTES < REPLY_DEPTH)
                        reply_bytes[byte_no - SENT_BYTES][bit_no] = 1'b1;
                    bit_pos++;
                    if (bit_no == 7) begin
                        if (bit_pos >= FRAME_BYTES * 8) begin
                            r.frame_done = 1'b1;
                            line_phase   = PH_SYNC;
                        end else begin
                            line_phase = PH_WAIT_NEXT;
                        end
                    end
                end
            end
            default: line_phase = PH_SYNC;
        endcase
        if (r.frame_done) begin
            r.reply2 = reply_bytes[0];
            r.reply3 = reply_bytes[1];
            r.reply4 = reply_bytes[2];
            r.reply5 = reply_bytes[3];
            r.reply6 = reply_bytes[4];
            r.reply7 = reply_bytes[5];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result          want;
        logic [DATA_W-1:0] reg_value;
        if (!i_rst_n) begin
            bit_period  = BIT_PERIOD_RST;
            sync_gap    = SYNC_GAP_RST;
            cmd_first   = '0;
            cmd_second  = '0;
            line_phase  = PH_SYNC;
            tick_count  = '0;
            bit_pos     = '0;
            reply_bytes = '{default: '0};
            tick_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (tick_q.size() == 0) begin
                    report_mismatch("result transfer with no tick pending");
                end else begin
                    want = tick_q.pop_front();
                    check_field("drive_strobe", 8'(o_drive_strobe),
                                8'(want.drive_strobe));
                    check_field("drive_value", 8'(o_drive_value),
                                8'(want.drive_value));
                    check_field("release_strobe", 8'(o_release_strobe),
                                8'(want.release_strobe));
                    check_field("frame_done", 8'(o_frame_done),
                                8'(want.frame_done));
                    check_field("reply_byte2", o_reply_byte2, want.reply2);
                    check_field("reply_byte3", o_reply_byte3, want.reply3);
                    check_field("reply_byte4", o_reply_byte4, want.reply4);
                    check_field("reply_byte5", o_reply_byte5, want.reply5);
                    check_field("reply_byte6", o_reply_byte6, want.reply6);
                    check_field("reply_byte7", o_reply_byte7, want.reply7);
                end
            end
            if (i_valid && !o_stall)
                tick_q.push_back(frame_tick(i_line_level));
            if (psel && penable && pready) begin
                case (paddr[3:2])
                    REG_BIT_PERIOD: reg_value = DATA_W'(bit_period);
                    REG_SYNC_GAP:   reg_value = DATA_W'(sync_gap);
                    REG_CMD_FIRST:  reg_value = DATA_W'(cmd_first);
                    default:        reg_value = DATA_W'(cmd_second);
                endcase
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_BIT_PERIOD: bit_period = pwdata[BP_W-1:0];
                        REG_SYNC_GAP:   sync_gap   = pwdata[GAP_W-1:0];
                        REG_CMD_FIRST:  cmd_first  = pwdata[CMD_W-1:0];
                        default:        cmd_second = pwdata[CMD_W-1:0];
                    endcase
                end else if (prdata !== reg_value) begin
                    report_mismatch($sformatf("register read at %0h got %0h want %0h",
                                              paddr, prdata, reg_value));
                end
            end
        end
        o_pending = tick_q.size();
    end

endmodule

// ----- sim/serial_remote_frame_controller_test.sv -----
// ----------------------------------------------------------------------------
// Frame controller testbench
// Drives line samples and register settings into the frame controller: a
// short directed opening, then phases of well-formed frames with random
// bytes, cut-off frames and line noise under several timing settings. The
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_remote_frame_controller_test;
    import srfc_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_line_level;
    logic                o_valid;
    logic                i_stall;
    logic                o_drive_strobe;
    logic                o_drive_value;
    logic                o_release_strobe;
    logic                o_frame_done;
    logic [7:0]          o_reply_byte2;
    logic [7:0]          o_reply_byte3;
    logic [7:0]          o_reply_byte4;
    logic [7:0]          o_reply_byte5;
    logic [7:0]          o_reply_byte6;
    logic [7:0]          o_reply_byte7;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    bit                  idle_on;
    int                  samples_sent;
    logic [BP_W-1:0]     bit_period_now;
    logic [GAP_W-1:0]    sync_gap_now;

    serial_remote_frame_controller dut (.*);

    serial_remote_frame_controller_checker chk (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_line_level = 1'b1;
        i_stall      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_on      = 1'b1;
        samples_sent = 0;
    end

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < 21);
    end

    initial begin
        #2_000_000;
        $display("serial_remote_frame_controller: mismatch");
        $finish;
    end

    // entered and left on a falling edge; valid stays high for a following sample
    task automatic put_line(input logic lvl);
        while (idle_on && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_line_level <= lvl;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    task automatic line_hold(input logic lvl, input int n);
        repeat (n) put_line(lvl);
    endtask

    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_timing(input logic [BP_W-1:0] bp, input logic [GAP_W-1:0] gap,
                              input t_byte c1, input t_byte c2);
        drain();
        apb_transfer(1'b1, REG_BIT_PERIOD, DATA_W'(bp));
        apb_transfer(1'b1, REG_SYNC_GAP, DATA_W'(gap));
        apb_transfer(1'b1, REG_CMD_FIRST, DATA_W'(c1));
        apb_transfer(1'b1, REG_CMD_SECOND, DATA_W'(c2));
        apb_transfer(1'b0, REG_BIT_PERIOD, '0);
        apb_transfer(1'b0, REG_SYNC_GAP, '0);
        apb_transfer(1'b0, REG_CMD_FIRST, '0);
        apb_transfer(1'b0, REG_CMD_SECOND, '0);
        bit_period_now = bp;
        sync_gap_now   = gap;
    endtask

    // sync gap, then n bytes: start bit, eight random bits, stop and slack
    task automatic send_frame(input int n);
        int unit;
        unit = (bit_period_now == 0) ? 1 : int'(bit_period_now);
        line_hold(1'b1, int'(sync_gap_now) + 1 + $urandom_range(0, 3));
        for (int b = 0; b < n; b++) begin
            line_hold(1'b0, unit);
            for (int k = 0; k < 8; k++)
                line_hold(1'($urandom_range(0, 1)), unit);
            line_hold(1'b1, unit + $urandom_range(0, unit));
        end
    endtask

    task automatic run_phase(input int budget);
        int first;
        int pick;
        first = samples_sent;
        while (samples_sent - first < budget) begin
            pick = $urandom_range(0, 99);
            if (bit_period_now <= 8 && pick < 70)
                send_frame(FRAME_BYTES);
            else if (bit_period_now <= 8 && pick < 85)
                send_frame($urandom_range(1, FRAME_BYTES - 1));
            else if (pick < 92)
                line_hold(1'b1, $urandom_range(1, 40));
            else
                repeat ($urandom_range(1, 20)) put_line(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        bit_period_now = BIT_PERIOD_RST;
        sync_gap_now   = SYNC_GAP_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, register read-back of defaults
        put_line(1'b1);
        put_line(1'b0);
        line_hold(1'b1, 2);
        drain();
        apb_transfer(1'b0, REG_BIT_PERIOD, '0);
        apb_transfer(1'b0, REG_SYNC_GAP, '0);
        apb_transfer(1'b0, REG_CMD_FIRST, '0);
        apb_transfer(1'b0, REG_CMD_SECOND, '0);

        // widest sync gap: the saturating counter never passes it
        set_timing(10'd1, 16'hFFFF, 8'h00, 8'hFF);
        line_hold(1'b1, 12);
        line_hold(1'b0, 2);
        line_hold(1'b1, 4);

        // zero bit period: every bit due at once
        set_timing(10'd0, 16'd1, 8'hFF, 8'h00);
        run_phase(90);
        set_timing(10'd1, 16'd1, 8'h00, 8'hFF);
        run_phase(90);
        for (int p = 0; p < 3; p++) begin
            idle_on = (p != 1);
            set_timing(10'($urandom_range(1, 3)), 16'($urandom_range(1, 24)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_phase(90);
        end
        idle_on = 1'b1;

        // longest bit period: only the frame start and noise fit
        set_timing(10'd1023, 16'd1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        line_hold(1'b1, 3);
        run_phase(90);
        set_timing(10'd2, 16'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(90);

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("serial_remote_frame_controller: match");
        else
            $display("serial_remote_frame_controller: mismatch");
        $finish;
    end

endmodule
